>>> rtl/core/fnvfh_pkg.sv
// Package: constants, types and shared helpers of the FNV-1a 64 / fmix64 hash block.
`default_nettype none
package fnvfh_pkg;

    localparam logic [63:0] FNV64_BASIS  = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FMIX64_MUL_A = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] FMIX64_MUL_B = 64'hC4CE_B9FE_1A85_EC53;
    localparam int unsigned FMIX_SHIFT   = 33;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int unsigned OUT_TDATA_W  = 72;

    // Queue status seen by the front (full) and the back (empty).
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // FNV-1a 64 fold: xor the byte in, multiply by 2^40 + 0x1B3 as a shift-add.
    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    function automatic logic [63:0] xor_shift(input logic [63:0] v);
        return v ^ (v >> FMIX_SHIFT);
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/fnvfh_front.sv
// Front end: start seed register, byte-wise FNV-1a fold and push of finished messages.
`default_nettype none
module fnvfh_front
    import fnvfh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [63:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] data_byte
    input  wire logic        s_tlast,
    input  wire queue_stat_t q_stat,
    output logic             push_valid,
    output logic [63:0]      push_data
);

    logic [63:0] start_seed_reg, start_seed_next;
    logic [63:0] hash_reg, hash_next;
    logic [63:0] start_value;
    logic [63:0] folded;
    logic        accept;

    assign s_tready = ~q_stat.full;
    assign accept   = s_tvalid & s_tready;
    assign folded   = fnv_fold(hash_reg, s_tdata);

    always_comb begin
        start_value = (cfg_wr_data == 64'd0) ? FNV64_BASIS : cfg_wr_data;
        start_seed_next = start_seed_reg;
        hash_next = hash_reg;
        if (cfg_wr_en) begin
            // a seed write reloads the running hash and drops any partial message
            start_seed_next = cfg_wr_data;
            hash_next = start_value;
        end else if (accept) begin
            if (s_tlast) begin
                hash_next = (start_seed_reg == 64'd0) ? FNV64_BASIS : start_seed_reg;
            end else begin
                hash_next = folded;
            end
        end
    end

    assign push_valid = accept & s_tlast & ~cfg_wr_en;
    assign push_data  = folded;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_seed_reg <= 64'd0;
            hash_reg <= FNV64_BASIS;
        end else begin
            start_seed_reg <= start_seed_next;
            hash_reg <= hash_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/fnvfh_queue.sv
// Short queue of folded message hashes between the front and the finalizer.
`default_nettype none
module fnvfh_queue
    import fnvfh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push_valid,
    input  wire logic [63:0] push_data,
    input  wire logic        pop,
    output logic [63:0]      pop_data,
    output queue_stat_t      q_stat
);

    localparam logic [QUEUE_AW:0] DEPTH_CNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    logic [63:0]         entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign q_stat.full  = (count_reg == DEPTH_CNT);
    assign q_stat.empty = (count_reg == '0);
    assign do_push  = push_valid & ~q_stat.full;
    assign do_pop   = pop & ~q_stat.empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/fnvfh_fmix.sv
// Back end: fmix64 finalizer on a shared 32x32 multiplier, with output register.
`default_nettype none
module fnvfh_fmix
    import fnvfh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire queue_stat_t q_stat,
    input  wire logic [63:0] pop_data,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata  // [63:0] digest, [65:64] variant, rest zero
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_MIX,
        ST_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] val_reg, val_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  phase_reg, phase_next;
    logic        pass_reg, pass_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] digest_reg, digest_next;

    logic [63:0] mul_k;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        out_free;

    assign mul_k    = pass_reg ? FMIX64_MUL_B : FMIX64_MUL_A;
    assign out_free = ~out_valid_reg | m_tready;

    // 64x64 low half as three 32x32 partial products, one per cycle
    always_comb begin
        unique case (phase_reg)
            2'd1:    begin mul_a = val_reg[63:32]; mul_b = mul_k[31:0];  end
            2'd2:    begin mul_a = val_reg[31:0];  mul_b = mul_k[63:32]; end
            default: begin mul_a = val_reg[31:0];  mul_b = mul_k[31:0];  end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb begin
        state_next     = state_reg;
        val_next       = val_reg;
        acc_next       = acc_reg;
        phase_next     = phase_reg;
        pass_next      = pass_reg;
        digest_next    = digest_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    pop        = 1'b1;
                    val_next   = xor_shift(pop_data);
                    phase_next = 2'd0;
                    pass_next  = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (phase_reg == 2'd0) begin
                    acc_next   = mul_p;
                    phase_next = 2'd1;
                end else begin
                    acc_next[63:32] = acc_reg[63:32] + mul_p[31:0];
                    if (phase_reg == 2'd2) begin
                        state_next = ST_MIX;
                    end else begin
                        phase_next = 2'd2;
                    end
                end
            end
            ST_MIX: begin
                val_next   = xor_shift(acc_reg);
                phase_next = 2'd0;
                if (pass_reg) begin
                    state_next = ST_DONE;
                end else begin
                    pass_next  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                // hold until the output register is free; force a zero digest to one
                if (out_free) begin
                    digest_next    = (val_reg == 64'd0) ? 64'd1 : val_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 2'd0;
            pass_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pass_reg <= pass_next;
            out_valid_reg <= out_valid_next;
        end
        val_reg <= val_next;
        acc_reg <= acc_next;
        digest_reg <= digest_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 66){1'b0}}, digest_reg[1:0], digest_reg};

endmodule
`default_nettype wire

>>> rtl/core/fnv1a64_fmix_hash_select.sv
// Top level: FNV-1a 64 message hash with fmix64 finalizer and four-way variant.
//
//  channel   dir  beat contents
//  s_        in   tdata[7:0] data_byte, tlast = last_byte
//  m_        out  tdata[63:0] digest, tdata[65:64] variant
//  cfg_wr_   in   start_seed, 64 bits, reloads the running hash
//
// The front folds one byte per cycle while the queue is not full; a beat with
// tlast pushes the folded hash into a two-entry queue. The finalizer handles one
// message at a time (pop, two multiplies of three 32x32 partial products each,
// two mix steps, hand-off to the output register) before it pops the next.
// s_tready drops only while the queue is full. Reset: synchronous, aresetn low;
// start seed clears to zero, which selects the FNV offset basis.
`default_nettype none
module fnv1a64_fmix_hash_select
    import fnvfh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [63:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata  // [63:0] digest, [65:64] variant, rest zero
);

    queue_stat_t q_stat;
    logic        push_valid;
    logic [63:0] push_data;
    logic        pop;
    logic [63:0] pop_data;

    fnvfh_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_stat      (q_stat),
        .push_valid  (push_valid),
        .push_data   (push_data)
    );

    fnvfh_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (pop),
        .pop_data   (pop_data),
        .q_stat     (q_stat)
    );

    fnvfh_fmix u_fmix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

>>> dv/tb.sv
// Testbench for the FNV-1a 64 / fmix64 hash block: directed table, random messages, scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TDATA_W       = fnvfh_pkg::OUT_TDATA_W;
    localparam int          ITEMS         = 1950;
    localparam int          N_PHASES      = 10;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          MAX_GAP       = 13;
    localparam int          PRINT_CAP     = 100;
    localparam logic [63:0] HASH_PRIME    = 64'h0000_0100_0000_01B3;
    localparam logic [63:0] HASH_BASIS    = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] MIX_K1        = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] MIX_K2        = 64'hC4CE_B9FE_1A85_EC53;
    localparam int          MIX_SHIFT     = 33;

    typedef enum logic [0:0] {ROW_BEAT, ROW_SEED} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [63:0] value;       // byte for a beat, start seed for a seed write
        logic        last;
        logic        typed;       // expected digest given in the row
        logic [63:0] exp_digest;
        logic [1:0]  exp_variant;
    } stim_row_t;

    typedef struct packed {
        logic [63:0] digest;
        logic [1:0]  variant;
    } digest_rec_t;

    localparam int DIR_N = 23;
    localparam stim_row_t DIR_ROWS [DIR_N] = '{
        '{ROW_BEAT, 64'h00, 1'b1, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'hFF, 1'b1, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'h01, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'h80, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'h7F, 1'b1, 1'b0, 64'h0, 2'd0},
        '{ROW_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'hAA, 1'b1, 1'b0, 64'h0, 2'd0},
        // seed equal to the byte folds to zero, which finalizes to zero: forced to one
        '{ROW_SEED, 64'h42, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'h42, 1'b1, 1'b1, 64'h1, 2'd1},
        '{ROW_SEED, 64'hFF, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'hFF, 1'b1, 1'b1, 64'h1, 2'd1},
        // open a message, then drop it with a seed write
        '{ROW_SEED, 64'h0, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'h11, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'h22, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_SEED, 64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'h33, 1'b1, 1'b0, 64'h0, 2'd0},
        // little-endian id then nonce bytes
        '{ROW_SEED, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'h78, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'h56, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'h34, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'h12, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'h01, 1'b0, 1'b0, 64'h0, 2'd0},
        '{ROW_BEAT, 64'h02, 1'b1, 1'b0, 64'h0, 2'd0}
    };

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [63:0]        cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;

    // predictor state
    logic [63:0] seed_reg;
    logic [63:0] acc_hash;
    digest_rec_t digest_q [$];
    digest_rec_t seen_rec;

    int unsigned mismatch_cnt = 0;
    int unsigned sent_beats   = 0;
    logic        tx_idle      = 1'b1;
    logic        rx_idle      = 1'b1;

    fnv1a64_fmix_hash_select dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] seed_start(input logic [63:0] s);
        return (s == 64'd0) ? HASH_BASIS : s;
    endfunction

    function automatic logic [63:0] fmix_finish(input logic [63:0] v);
        logic [63:0] m;
        m = v ^ (v >> MIX_SHIFT);
        m = m * MIX_K1;
        m = m ^ (m >> MIX_SHIFT);
        m = m * MIX_K2;
        m = m ^ (m >> MIX_SHIFT);
        return (m == 64'd0) ? 64'd1 : m;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (mismatch_cnt < PRINT_CAP)
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_cnt++;
    endtask

    // Offer one byte beat, wait for it to be taken, then fold it into the predictor.
    task automatic send_beat(input logic [7:0] d, input logic l, input logic typed,
                             input logic [63:0] t_digest, input logic [1:0] t_variant);
        int unsigned gap;
        digest_rec_t rec;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        sent_beats++;
        acc_hash = (acc_hash ^ {56'd0, d}) * HASH_PRIME;
        if (l) begin
            rec.digest  = typed ? t_digest : fmix_finish(acc_hash);
            rec.variant = typed ? t_variant : rec.digest[1:0];
            digest_q.push_back(rec);
            acc_hash = seed_start(seed_reg);
        end
    endtask

    task automatic send_message(input int unsigned len, input logic closed);
        for (int unsigned i = 0; i < len; i++)
            send_beat(8'($urandom_range(0, 255)), closed && (i == len - 1), 1'b0, 64'd0, 2'd0);
    endtask

    // Hold the input idle until every digest is back and the finalizer has run dry.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [63:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        seed_reg  = v;
        acc_hash  = seed_start(v);
    endtask

    function automatic logic [63:0] pick_seed(input int unsigned phase);
        if (phase == 0)
            return 64'd0;
        if (phase == 1)
            return 64'hFFFF_FFFF_FFFF_FFFF;
        case ($urandom_range(0, 5))
            0:       return 64'd0;
            1:       return 64'hFFFF_FFFF_FFFF_FFFF;
            2:       return 64'd1;
            3:       return {32'd0, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // result side: draw a stall per beat, then hold ready until a beat is taken
    initial begin
        int unsigned stall;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                report("unexpected digest beat", m_tdata[63:0], 64'd0);
            end else begin
                seen_rec = digest_q.pop_front();
                if (m_tdata[63:0] !== seen_rec.digest)
                    report("digest", m_tdata[63:0], seen_rec.digest);
                if (m_tdata[65:64] !== seen_rec.variant)
                    report("variant", 64'(m_tdata[65:64]), 64'(seen_rec.variant));
                if (m_tdata[TDATA_W-1:66] !== '0)
                    report("padding", 64'(m_tdata[TDATA_W-1:66]), 64'd0);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int unsigned budget;
        int unsigned len;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 64'd0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 8'd0;
        s_tlast     <= 1'b0;
        seed_reg     = 64'd0;
        acc_hash     = HASH_BASIS;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].kind == ROW_SEED) begin
                settle();
                write_seed(DIR_ROWS[i].value);
            end else begin
                send_beat(DIR_ROWS[i].value[7:0], DIR_ROWS[i].last, DIR_ROWS[i].typed,
                          DIR_ROWS[i].exp_digest, DIR_ROWS[i].exp_variant);
            end
        end

        budget = (ITEMS - sent_beats) / N_PHASES;
        for (int unsigned phase = 0; phase < N_PHASES; phase++) begin
            settle();
            write_seed(pick_seed(phase));
            // one phase in three runs flat out on both sides
            case (phase % 3)
                0: begin
                    tx_idle = 1'b1;
                    rx_idle = 1'b1;
                end
                1: begin
                    tx_idle = 1'b0;
                    rx_idle = 1'b0;
                end
                default: begin
                    tx_idle = 1'($urandom_range(0, 1));
                    rx_idle = 1'($urandom_range(0, 1));
                end
            endcase
            while (sent_beats < ITEMS - budget * (N_PHASES - 1 - phase)) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                  : $urandom_range(1, 8);
                send_message(len, 1'b1);
            end
            // leave a broken message open; the next seed write drops it
            if (phase != N_PHASES - 1 && $urandom_range(0, 1) == 1)
                send_message($urandom_range(1, 5), 1'b0);
        end

        settle();
        if (mismatch_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
